/* rtl/core/vtek_pkg.sv */
// Package for the terminal escape key decoder: byte constants, key kinds,
// special key codes, decoder phases and the decode result struct.
// No dependencies.
package vtek_pkg;

  // Bytes that carry meaning in an escape sequence.
  localparam logic [7:0] BYTE_ESC     = 8'h1B;
  localparam logic [7:0] BYTE_BRACKET = 8'h5B;
  localparam logic [7:0] BYTE_TILDE   = 8'h7E;
  localparam logic [7:0] BYTE_ZERO    = 8'h30;
  localparam logic [7:0] BYTE_NINE    = 8'h39;

  // Key kinds.
  localparam logic [1:0] KIND_PLAIN    = 2'd0;
  localparam logic [1:0] KIND_LONE_ESC = 2'd1;
  localparam logic [1:0] KIND_ALT      = 2'd2;
  localparam logic [1:0] KIND_SPECIAL  = 2'd3;

  // Special key codes.
  localparam logic [7:0] SP_HOME     = 8'd0;
  localparam logic [7:0] SP_END      = 8'd1;
  localparam logic [7:0] SP_DELETE   = 8'd2;
  localparam logic [7:0] SP_PAGEUP   = 8'd3;
  localparam logic [7:0] SP_PAGEDOWN = 8'd4;
  localparam logic [7:0] SP_UP       = 8'd5;
  localparam logic [7:0] SP_DOWN     = 8'd6;
  localparam logic [7:0] SP_RIGHT    = 8'd7;
  localparam logic [7:0] SP_LEFT     = 8'd8;

  // Decoder phases.
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_ESC     = 2'd1;
  localparam logic [1:0] PH_BRACKET = 2'd2;
  localparam logic [1:0] PH_DIGIT   = 2'd3;

  localparam int unsigned DigitW = 4;

  typedef struct packed {
    logic              res_vld;
    logic [1:0]        kind;
    logic [7:0]        code;
    logic [1:0]        phase;
    logic [DigitW-1:0] digit;
  } dec_t;

  // Special key for ESC [ digit ~; the flag is low where the digit has no meaning.
  function automatic logic [8:0] tilde_key(input logic [DigitW-1:0] digit);
    logic [8:0] r;
    case (digit)
      4'd1:    r = {1'b1, SP_HOME};
      4'd3:    r = {1'b1, SP_DELETE};
      4'd4:    r = {1'b1, SP_END};
      4'd5:    r = {1'b1, SP_PAGEUP};
      4'd6:    r = {1'b1, SP_PAGEDOWN};
      4'd7:    r = {1'b1, SP_HOME};
      4'd8:    r = {1'b1, SP_END};
      default: r = {1'b0, SP_HOME};
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/vtek_decode.sv */
// Combinational decode of one terminal byte against the current phase.
// Depends on vtek_pkg.
module vtek_decode import vtek_pkg::*; (
  input  logic [1:0]        phase_i,
  input  logic [DigitW-1:0] digit_i,
  input  logic [7:0]        byte_i,
  output dec_t              dec_o
);

  logic [8:0] tk;
  logic [3:0] letter;   // {hit, alt index}
  logic [8:0] arrow;    // {hit, special code}

  assign tk = tilde_key(digit_i);

  always_comb begin
    case (byte_i)
      8'h66:   letter = {1'b1, 3'd0};  // f
      8'h62:   letter = {1'b1, 3'd1};  // b
      8'h64:   letter = {1'b1, 3'd2};  // d
      8'h6C:   letter = {1'b1, 3'd3};  // l
      8'h75:   letter = {1'b1, 3'd4};  // u
      8'h63:   letter = {1'b1, 3'd5};  // c
      8'h74:   letter = {1'b1, 3'd6};  // t
      8'h79:   letter = {1'b1, 3'd7};  // y
      default: letter = 4'd0;
    endcase
  end

  always_comb begin
    case (byte_i)
      8'h41:   arrow = {1'b1, SP_UP};
      8'h42:   arrow = {1'b1, SP_DOWN};
      8'h43:   arrow = {1'b1, SP_RIGHT};
      8'h44:   arrow = {1'b1, SP_LEFT};
      8'h48:   arrow = {1'b1, SP_HOME};
      8'h46:   arrow = {1'b1, SP_END};
      default: arrow = 9'd0;
    endcase
  end

  always_comb begin
    // Default: a lone escape ends the sequence.
    dec_o.res_vld = 1'b1;
    dec_o.kind    = KIND_LONE_ESC;
    dec_o.code    = BYTE_ESC;
    dec_o.phase   = PH_IDLE;
    dec_o.digit   = digit_i;
    case (phase_i)
      PH_IDLE: begin
        if (byte_i == BYTE_ESC) begin
          dec_o.res_vld = 1'b0;
          dec_o.phase   = PH_ESC;
        end else begin
          dec_o.kind = KIND_PLAIN;
          dec_o.code = byte_i;
        end
      end
      PH_ESC: begin
        if (letter[3]) begin
          dec_o.kind = KIND_ALT;
          dec_o.code = {5'd0, letter[2:0]};
        end else if (byte_i == BYTE_BRACKET) begin
          dec_o.res_vld = 1'b0;
          dec_o.phase   = PH_BRACKET;
        end
      end
      PH_BRACKET: begin
        if (byte_i >= BYTE_ZERO && byte_i <= BYTE_NINE) begin
          dec_o.res_vld = 1'b0;
          dec_o.phase   = PH_DIGIT;
          dec_o.digit   = byte_i[DigitW-1:0];
        end else if (arrow[8]) begin
          dec_o.kind = KIND_SPECIAL;
          dec_o.code = arrow[7:0];
        end
      end
      default: begin
        if (byte_i == BYTE_TILDE && tk[8]) begin
          dec_o.kind = KIND_SPECIAL;
          dec_o.code = tk[7:0];
        end
      end
    endcase
  end

endmodule

/* rtl/core/vt_escape_key_decoder.sv */
// Top level of the terminal escape key decoder: phase registers, decode stage
// and a two-entry output buffer. Depends on vtek_pkg and vtek_decode.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o | in_byte_i[7:0]
//   out     | output    | out_valid_o/out_ready_i | key_kind_o[1:0], key_code_o[7:0]
//
// One byte is accepted per cycle while the skid entry is empty; the single decode stage sets that figure.
// A key is registered in the output register, or in the skid entry while the output register holds an untaken key.
// The output register plus a skid entry keep input open while one key waits;
// input stalls only when both hold keys.
// Reset clears the phase, the held digit and both buffer valid flags.
module vt_escape_key_decoder import vtek_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] key_kind_o,
  output logic [7:0] key_code_o
);

  logic [1:0]        phase_q;
  logic [DigitW-1:0] digit_q;
  dec_t              dec;

  logic       out_vld_q, skid_vld_q;
  logic [1:0] out_kind_q, skid_kind_q;
  logic [7:0] out_code_q, skid_code_q;
  logic       in_acc, out_take;

  vtek_decode u_decode (
    .phase_i (phase_q),
    .digit_i (digit_q),
    .byte_i  (in_byte_i),
    .dec_o   (dec)
  );

  assign in_ready_o  = ~skid_vld_q;
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_take    = out_vld_q & out_ready_i;
  assign out_valid_o = out_vld_q;
  assign key_kind_o  = out_kind_q;
  assign key_code_o  = out_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      digit_q <= '0;
    end else if (in_acc) begin
      phase_q <= dec.phase;
      digit_q <= dec.digit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (in_acc && dec.res_vld) begin
      if (out_vld_q && !out_ready_i) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_q <= 1'b0;
    end
  end

  // Payload registers follow the valid flags above.
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) begin
        out_kind_q <= skid_kind_q;
        out_code_q <= skid_code_q;
      end
    end else if (in_acc && dec.res_vld) begin
      if (out_vld_q && !out_ready_i) begin
        skid_kind_q <= dec.kind;
        skid_code_q <= dec.code;
      end else begin
        out_kind_q <= dec.kind;
        out_code_q <= dec.code;
      end
    end
  end

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry holds a key while the output register is empty");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && dec.res_vld && !out_vld_q) |=> (out_vld_q && !skid_vld_q))
    else $error("decoded key did not reach the output register");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DIGIT) |-> (digit_q <= 4'd9))
    else $error("held digit out of range in digit phase");

  a_lone_esc_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_kind_q == KIND_LONE_ESC) |-> (out_code_q == BYTE_ESC))
    else $error("lone escape key carries a wrong code");

  a_no_result_keeps_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !dec.res_vld && !out_vld_q) |=> !out_vld_q)
    else $error("a byte without a key produced an output transaction");

endmodule
